// ----- rtl/core/seven_segment_scan_driver_macros.svh -----
// Assertion macros for the seven-segment scan driver checks.
`ifndef SEVEN_SEGMENT_SCAN_DRIVER_MACROS_SVH
`define SEVEN_SEGMENT_SCAN_DRIVER_MACROS_SVH

// Same-cycle implication, sampled on the rising edge, off while rst is high.
`define SSD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on the rising edge, off while rst is high.
`define SSD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/ssd_pkg.sv -----
// Shared types, constants and segment tables for the seven-segment scan driver.
`default_nettype none

package ssd_pkg;

   typedef enum logic [1:0] {
      MODE_TICK   = 2'd0,
      MODE_NUMBER = 2'd1,
      MODE_CHARS  = 2'd2,
      MODE_NONE   = 2'd3
   } ssd_mode_type;

   localparam int unsigned CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TICKS_PER_UPDATE = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_AUTO_COUNT       = 1'd1;

   localparam int unsigned MODE_W      = 2;
   localparam int unsigned NUMBER_W    = 15;
   localparam int unsigned CHARS_W     = 32;
   localparam int unsigned CSR_DATA_W  = 16;
   localparam int unsigned TICK_W      = 16;
   localparam int unsigned COUNT_W     = 14;
   localparam int unsigned REQ_TDATA_W = 48;
   localparam int unsigned RSP_TDATA_W = 32;
   localparam int unsigned RSP_PAD_W   = 4;
   localparam int unsigned COUNT_DIGITS = 4;
   localparam int unsigned CHAR_SLOTS   = 4;

   localparam logic [TICK_W-1:0]  PERIOD_RESET = 16'd200;
   localparam logic [COUNT_W-1:0] COUNT_MAX    = 14'd9999;

   localparam logic [7:0] ZERO_CODE  = 8'hC0;
   localparam logic [7:0] MINUS_CODE = 8'hBF;
   localparam logic [7:0] BLANK_CODE = 8'hFF;

   // next-state view of the counter for the current tick
   typedef struct packed {
      logic                               redraw;
      logic [COUNT_W-1:0]                 count;
      logic [COUNT_DIGITS-1:0][3:0]       bcd;
   } ssd_cnt_type;

   function automatic logic [7:0] digit_seg(input logic [3:0] d);
      logic [7:0] code;
      case (d)
         4'd0:    code = 8'hC0;
         4'd1:    code = 8'hF9;
         4'd2:    code = 8'hA4;
         4'd3:    code = 8'hB0;
         4'd4:    code = 8'h99;
         4'd5:    code = 8'h92;
         4'd6:    code = 8'h82;
         4'd7:    code = 8'hF8;
         4'd8:    code = 8'h80;
         4'd9:    code = 8'h90;
         default: code = BLANK_CODE;
      endcase
      return code;
   endfunction

   // hex letter A-F / a-f, picked by the low three bits of the ASCII code
   function automatic logic [7:0] letter_seg(input logic [2:0] k, input logic lower);
      logic [7:0] code;
      case (k)
         3'd1:    code = lower ? 8'hA0 : 8'h88;
         3'd2:    code = lower ? 8'h83 : 8'h80;
         3'd3:    code = lower ? 8'hA7 : 8'hC6;
         3'd4:    code = lower ? 8'hA1 : 8'hC0;
         3'd5:    code = lower ? 8'h84 : 8'h86;
         3'd6:    code = 8'h8E;
         default: code = BLANK_CODE;
      endcase
      return code;
   endfunction

   function automatic logic [7:0] char_seg(input logic [7:0] c);
      logic [7:0] code;
      if (c >= 8'h30 && c <= 8'h39) begin
         code = digit_seg(c[3:0]);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         code = letter_seg(c[2:0], 1'b0);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         code = letter_seg(c[2:0], 1'b1);
      end else begin
         code = BLANK_CODE;
      end
      return code;
   endfunction

   // floor(v / 10^i) via ceil(2^30 / 10^i); exact for v < 2^15, i <= 4
   function automatic logic [NUMBER_W-1:0] dec_quot(input logic [NUMBER_W-1:0] v,
                                                    input int unsigned i);
      logic [30:0] m;
      logic [45:0] p;
      case (i)
         0:       m = 31'd1073741824;
         1:       m = 31'd107374183;
         2:       m = 31'd10737419;
         3:       m = 31'd1073742;
         4:       m = 31'd107375;
         default: m = '0;
      endcase
      p = 46'(v) * 46'(m);
      return p[44:30];
   endfunction

endpackage

`default_nettype wire

// ----- rtl/core/ssd_split.sv -----
// Signed number to per-digit segment codes (constant-divisor digit split).
`default_nettype none

module ssd_split #(
   parameter int unsigned DIGITS = 4
) (
   input  logic [ssd_pkg::NUMBER_W-1:0] number,
   output logic [DIGITS-1:0][7:0]       codes
);
   import ssd_pkg::*;

   logic                             neg;
   logic [NUMBER_W-1:0]              mag;
   logic [NUMBER_W-1:0]              value;
   logic [DIGITS:0][NUMBER_W-1:0]    quot;

   assign neg   = number[NUMBER_W-1];
   assign mag   = ~number + NUMBER_W'(1);
   assign value = neg ? mag : number;

   for (genvar i = 0; i <= DIGITS; i++) begin : g_quot
      assign quot[i] = dec_quot(value, i);
   end

   for (genvar i = 0; i < DIGITS; i++) begin : g_digit
      logic [3:0] digit;
      // q_i - 10*q_(i+1), only the low nibble matters
      assign digit = quot[i][3:0] - 4'((quot[i+1] << 3) + (quot[i+1] << 1));
      if (i == DIGITS - 1) begin : g_top
         assign codes[i] = neg ? MINUS_CODE : digit_seg(digit);
      end else begin : g_low
         assign codes[i] = digit_seg(digit);
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/ssd_counter.sv -----
// Tick divider plus binary and BCD decimal counter.
`default_nettype none

module ssd_counter (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       tick,
   input  logic [ssd_pkg::TICK_W-1:0] period,
   input  logic                       auto_count,
   output ssd_pkg::ssd_cnt_type       cnt_next
);
   import ssd_pkg::*;

   logic [TICK_W-1:0]             tick_count_ff, tick_count_in;
   logic [COUNT_W-1:0]            count_ff, count_in;
   logic [COUNT_DIGITS-1:0][3:0]  bcd_ff, bcd_in;
   logic [TICK_W-1:0]             tick_inc;
   logic                          hit;
   logic                          carry;
   logic [COUNT_DIGITS-1:0][3:0]  bcd_inc;

   always_comb begin
      tick_inc = tick_count_ff + TICK_W'(1);
      hit      = (tick_inc == period);

      carry = 1'b1;
      for (int d = 0; d < COUNT_DIGITS; d++) begin
         bcd_inc[d] = bcd_ff[d];
         if (carry) begin
            if (bcd_ff[d] == 4'd9) begin
               bcd_inc[d] = 4'd0;
            end else begin
               bcd_inc[d] = bcd_ff[d] + 4'd1;
               carry      = 1'b0;
            end
         end
      end

      cnt_next.redraw = hit && auto_count;
      cnt_next.count  = count_ff;
      cnt_next.bcd    = bcd_ff;
      if (cnt_next.redraw) begin
         cnt_next.count = (count_ff == COUNT_MAX) ? '0 : count_ff + COUNT_W'(1);
         cnt_next.bcd   = bcd_inc;
      end

      tick_count_in = tick_count_ff;
      count_in      = count_ff;
      bcd_in        = bcd_ff;
      if (tick) begin
         tick_count_in = hit ? '0 : tick_inc;
         count_in      = cnt_next.count;
         bcd_in        = cnt_next.bcd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_count_ff <= '0;
         count_ff      <= '0;
         bcd_ff        <= '0;
      end else begin
         tick_count_ff <= tick_count_in;
         count_ff      <= count_in;
         bcd_ff        <= bcd_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/seven_segment_scan_driver.sv -----
// Top level of the multiplexed seven-segment scan driver.
//
//   channel  direction  handshake                 payload
//   req      in         req_tvalid / req_tready   tuser: mode; tdata: number, chars
//   rsp      out        rsp_tvalid / rsp_tready   tdata: index, enable, segments, count
//   csr      in         csr_we                    csr_index, csr_wdata
//
// One item per cycle sustained while the rsp side keeps up: a transfer lands in the input register,
// then updates the counter, digit codes and scan index and loads the result register.
// A tick goes from req through the input register and then the result register to rsp; loads give no result.
// Synchronous reset clears control state, the counter and shows zeros on all digits.
// A tick stalls only while the result register is full and not being taken;
// load items move on regardless of the rsp side.
`default_nettype none

module seven_segment_scan_driver #(
   parameter int unsigned DIGITS = 4
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [ssd_pkg::REQ_TDATA_W-1:0] req_tdata,   // number[14:0], chars[46:15], pad
   input  logic [ssd_pkg::MODE_W-1:0]      req_tuser,   // mode[1:0]
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [ssd_pkg::RSP_TDATA_W-1:0] rsp_tdata,   // index[1:0], enable[5:2],
                                                        // segments[13:6], count[27:14], pad
   input  logic                            csr_we,
   input  logic [ssd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [ssd_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import ssd_pkg::*;

   localparam int unsigned SCAN_W = $clog2(DIGITS);

   // configuration
   logic [TICK_W-1:0]            period_ff, period_in;
   logic                         auto_count_ff, auto_count_in;

   // input register
   logic                         in_valid_ff, in_valid_in;
   ssd_mode_type                 in_mode_ff;
   logic [NUMBER_W-1:0]          in_number_ff;
   logic [CHARS_W-1:0]           in_chars_ff;

   // display state
   logic [DIGITS-1:0][7:0]       codes_ff, codes_in;
   logic [SCAN_W-1:0]            scan_ff, scan_in;

   // result register
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [1:0]                   rsp_index_ff, rsp_index_in;
   logic [3:0]                   rsp_enable_ff, rsp_enable_in;
   logic [7:0]                   rsp_segments_ff;
   logic [COUNT_W-1:0]           rsp_count_ff;

   logic                         req_xfer;
   logic                         out_free;
   logic                         go;
   logic                         tick;
   logic [DIGITS-1:0]            onehot;
   logic [DIGITS-1:0][7:0]       split_codes;
   ssd_cnt_type                  cnt_next;

   // ---- handshake -------------------------------------------------------
   // a tick needs room in the result register; loads and mode 3 never do
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign go         = in_valid_ff && ((in_mode_ff != MODE_TICK) || out_free);
   assign tick       = go && (in_mode_ff == MODE_TICK);
   assign req_tready = !in_valid_ff || go;
   assign req_xfer   = req_tvalid && req_tready;

   assign in_valid_in  = req_tready ? req_tvalid : in_valid_ff;
   assign rsp_valid_in = tick ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   // ---- configuration writes -------------------------------------------
   always_comb begin
      period_in     = period_ff;
      auto_count_in = auto_count_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_TICKS_PER_UPDATE: period_in     = csr_wdata;
            CSR_AUTO_COUNT:       auto_count_in = csr_wdata[0];
            default: ;
         endcase
      end
   end

   // ---- datapath units -------------------------------------------------
   ssd_split #(
      .DIGITS (DIGITS)
   ) u_split (
      .number (in_number_ff),
      .codes  (split_codes)
   );

   ssd_counter u_counter (
      .clock      (clock),
      .reset      (reset),
      .tick       (tick),
      .period     (period_ff),
      .auto_count (auto_count_ff),
      .cnt_next   (cnt_next)
   );

   // ---- digit code store: per-digit next value ---------------------------
   for (genvar d = 0; d < DIGITS; d++) begin : g_digit
      logic [7:0] char_code;
      logic [7:0] count_code;
      logic [7:0] next_code;

      // only the four low digits take characters or counter digits
      if (d < CHAR_SLOTS) begin : g_char
         assign char_code = char_seg(in_chars_ff[8*d +: 8]);
      end else begin : g_keep
         assign char_code = codes_ff[d];
      end
      if (d < COUNT_DIGITS) begin : g_cnt
         assign count_code = digit_seg(cnt_next.bcd[d]);
      end else begin : g_zero
         assign count_code = ZERO_CODE;
      end

      always_comb begin
         next_code = codes_ff[d];
         if (go) begin
            case (in_mode_ff)
               MODE_NUMBER: next_code = split_codes[d];
               MODE_CHARS:  next_code = char_code;
               MODE_TICK:   if (cnt_next.redraw) next_code = count_code;
               default: ;
            endcase
         end
      end

      assign codes_in[d] = next_code;
   end

   // ---- scan and result fields -------------------------------------------
   assign scan_in = !tick ? scan_ff
                  : (scan_ff == SCAN_W'(DIGITS - 1)) ? '0 : scan_ff + SCAN_W'(1);
   assign onehot  = DIGITS'(1) << scan_ff;

   // fields narrower than the scan range are masked to their widths
   for (genvar b = 0; b < 2; b++) begin : g_index
      if (b < SCAN_W) begin : g_bit
         assign rsp_index_in[b] = scan_ff[b];
      end else begin : g_pad
         assign rsp_index_in[b] = 1'b0;
      end
   end
   for (genvar b = 0; b < 4; b++) begin : g_enable
      if (b < DIGITS) begin : g_bit
         assign rsp_enable_in[b] = onehot[b];
      end else begin : g_pad
         assign rsp_enable_in[b] = 1'b0;
      end
   end

   // ---- registers -------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff     <= PERIOD_RESET;
         auto_count_ff <= 1'b1;
         in_valid_ff   <= 1'b0;
         codes_ff      <= {DIGITS{ZERO_CODE}};
         scan_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         period_ff     <= period_in;
         auto_count_ff <= auto_count_in;
         in_valid_ff   <= in_valid_in;
         codes_ff      <= codes_in;
         scan_ff       <= scan_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_mode_ff   <= ssd_mode_type'(req_tuser);
         in_number_ff <= req_tdata[NUMBER_W-1:0];
         in_chars_ff  <= req_tdata[NUMBER_W +: CHARS_W];
      end
      if (tick) begin
         rsp_index_ff    <= rsp_index_in;
         rsp_enable_ff   <= rsp_enable_in;
         rsp_segments_ff <= codes_in[scan_ff];
         rsp_count_ff    <= cnt_next.count;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, rsp_count_ff, rsp_segments_ff,
                        rsp_enable_ff, rsp_index_ff};

endmodule

`default_nettype wire

// ----- rtl/core/ssd_checker.sv -----
// Port-level checks for the seven-segment scan driver, bound to the top level.
`default_nettype none

module ssd_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic [ssd_pkg::REQ_TDATA_W-1:0] req_tdata,
   input logic [ssd_pkg::MODE_W-1:0]      req_tuser,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [ssd_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input logic                            csr_we,
   input logic [ssd_pkg::CSR_INDEX_W-1:0] csr_index,
   input logic [ssd_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import ssd_pkg::*;
   `include "seven_segment_scan_driver_macros.svh"

   logic [1:0]         rsp_index;
   logic [3:0]         rsp_enable;
   logic [COUNT_W-1:0] rsp_count;

   assign rsp_index  = rsp_tdata[1:0];
   assign rsp_enable = rsp_tdata[5:2];
   assign rsp_count  = rsp_tdata[27:14];

   `SSD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid, "rsp dropped while stalled")
   `SSD_ASSERT_NOW(a_enable_match, clock, reset, rsp_tvalid && (rsp_enable != 4'd0), rsp_enable == (4'd1 << rsp_index), "digit enable disagrees with index")
   `SSD_ASSERT_NOW(a_count_range, clock, reset, rsp_tvalid, rsp_count <= COUNT_MAX, "counter beyond 9999")
   `SSD_ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, req_tready && !rsp_tvalid, "not idle after reset")

endmodule

bind seven_segment_scan_driver ssd_checker u_ssd_checker (.*);

`default_nettype wire
